[rtl/core/hcmb_pkg.sv]
`default_nettype none
package hcmb_pkg;

  // Access modes carried by a request
  localparam logic [2:0] MODE_RD_BYTE = 3'd0;
  localparam logic [2:0] MODE_WR_BYTE = 3'd1;
  localparam logic [2:0] MODE_RD_WORD = 3'd2;
  localparam logic [2:0] MODE_WR_WORD = 3'd3;
  localparam logic [2:0] MODE_PUSH    = 3'd4;
  localparam logic [2:0] MODE_POP     = 3'd5;
  localparam logic [2:0] MODE_LOAD_SP = 3'd6;

  // Address map boundaries
  localparam logic [15:0] ROM_MASK   = 16'h7FFF;
  localparam logic [15:0] BANK_MASK  = 16'h1FFF;
  localparam logic [15:0] ECHO_BASE  = 16'hE000;
  localparam logic [15:0] ECHO_END   = 16'hFE00;
  localparam logic [15:0] SPRITE_END = 16'hFEA0;
  localparam logic [15:0] IO_BASE    = 16'hFF00;
  localparam logic [15:0] HIGH_BASE  = 16'hFF80;
  localparam logic [15:0] SP_RESET   = 16'hFFFE;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic launch;  // first byte access, taken from the request ports
    logic second;  // second byte access, taken from held request
  } cmd_t;

  // Decoded location of one bus address in the physical byte array
  typedef struct packed {
    logic        hit;
    logic [15:0] idx;
  } phys_t;

  // Fold the echo onto work RAM and flag the unmapped hole.
  // Every other region keeps its bus address as the array index.
  function automatic phys_t bus_map(logic [15:0] a);
    phys_t p;
    p.hit = 1'b1;
    p.idx = a;
    if (a >= ECHO_BASE && a < ECHO_END) begin
      p.idx = a & ~(BANK_MASK + 16'd1);
    end else if (a >= SPRITE_END && a < IO_BASE) begin
      p.hit = 1'b0;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

[rtl/core/hcmb_ctrl.sv]
`default_nettype none
module hcmb_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output      logic         busy,
  output      logic         out_valid,
  output      hcmb_pkg::cmd_t cmd
);
  import hcmb_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SECOND = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Sequence: accept, second byte access, result strobe
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SECOND;
      ST_SECOND: state_nxt = ST_DONE;
      ST_DONE:   state_nxt = start ? ST_SECOND : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive handshake and datapath commands
  assign busy       = (state_r == ST_SECOND);
  assign out_valid  = (state_r == ST_DONE);
  assign cmd.launch = start && !busy;
  assign cmd.second = busy;

endmodule
`default_nettype wire

[rtl/core/hcmb_datapath.sv]
`default_nettype none
module hcmb_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire hcmb_pkg::cmd_t cmd,
  input  wire logic [2:0]     in_mode,
  input  wire logic [15:0]    in_address,
  input  wire logic [15:0]    in_data,
  output      logic [15:0]    out_read_data,
  output      logic [15:0]    out_stack_value
);
  import hcmb_pkg::*;

  // Byte array covering every mapped region; echo cells fold onto work RAM
  logic [7:0]  mem [0:65535];
  logic [7:0]  rdq_r;

  logic [15:0] sp_r, sp_nxt;
  logic [2:0]  mode_r;
  logic [15:0] ea1_r;
  logic [7:0]  hi_data_r;
  logic [7:0]  lo_r;
  logic        hit0_r, hit1_r;

  logic [15:0] ea0;
  phys_t       ph0, ph1;
  logic        is_rd_in, is_wr_in, is_rd_r, is_wr_r;
  logic        mem_we, mem_re;
  logic [15:0] mem_widx, mem_ridx;
  logic [7:0]  mem_wd;
  logic [7:0]  lo_byte, hi_byte;

  // Pick the first byte address from the request or the stack pointer
  always_comb begin
    case (in_mode)
      MODE_PUSH: ea0 = sp_r - 16'd2;
      MODE_POP:  ea0 = sp_r;
      default:   ea0 = in_address;
    endcase
  end

  assign ph0 = bus_map(ea0);
  assign ph1 = bus_map(ea1_r);

  assign is_rd_in = (in_mode == MODE_RD_BYTE) || (in_mode == MODE_RD_WORD) ||
                    (in_mode == MODE_POP);
  assign is_wr_in = (in_mode == MODE_WR_BYTE) || (in_mode == MODE_WR_WORD) ||
                    (in_mode == MODE_PUSH);
  assign is_rd_r  = (mode_r == MODE_RD_WORD) || (mode_r == MODE_POP);
  assign is_wr_r  = (mode_r == MODE_WR_WORD) || (mode_r == MODE_PUSH);

  // Steer the single memory port: low byte on launch, high byte second
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_widx = ph0.idx;
    mem_ridx = ph0.idx;
    mem_wd   = in_data[7:0];
    if (cmd.launch) begin
      mem_we = is_wr_in && ph0.hit;
      mem_re = is_rd_in && ph0.hit;
    end else if (cmd.second) begin
      mem_widx = ph1.idx;
      mem_ridx = ph1.idx;
      mem_wd   = hi_data_r;
      mem_we   = is_wr_r && ph1.hit;
      mem_re   = is_rd_r && ph1.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wd;
    end
    if (mem_re) begin
      rdq_r <= mem[mem_ridx];
    end
  end

  // Update the stack pointer when the request is taken
  always_comb begin
    sp_nxt = sp_r;
    if (cmd.launch) begin
      case (in_mode)
        MODE_PUSH:    sp_nxt = sp_r - 16'd2;
        MODE_POP:     sp_nxt = sp_r + 16'd2;
        MODE_LOAD_SP: sp_nxt = in_data;
        default:      sp_nxt = sp_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= SP_RESET;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  // Hold the request for the second access and the result
  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      mode_r    <= in_mode;
      ea1_r     <= ea0 + 16'd1;
      hi_data_r <= in_data[15:8];
      hit0_r    <= ph0.hit;
    end
    if (cmd.second) begin
      lo_r   <= rdq_r;
      hit1_r <= ph1.hit;
    end
  end

  // Assemble the result; unmapped bytes read as zero
  assign lo_byte = hit0_r ? lo_r  : 8'h00;
  assign hi_byte = hit1_r ? rdq_r : 8'h00;

  always_comb begin
    case (mode_r)
      MODE_RD_BYTE: out_read_data = {8'h00, lo_byte};
      MODE_RD_WORD: out_read_data = {hi_byte, lo_byte};
      MODE_POP:     out_read_data = {hi_byte, lo_byte};
      default:      out_read_data = 16'h0000;
    endcase
  end

  assign out_stack_value = sp_r;

endmodule
`default_nettype wire

[rtl/core/handheld_console_memory_bus_unit.sv]
`default_nettype none
// Memory bus of a handheld console: a 16-bit address decodes into cartridge
// ROM (writable), video, external and work RAM (with echo), sprite table, I/O
// and high RAM; FEA0-FEFF reads zero and drops writes. A request is taken
// when start is high and busy is low. The byte array has one port, so a word
// access makes its low byte access at the accept edge and its high byte
// access in the following busy cycle. The result appears on out_read_data
// and out_stack_value, with out_valid high for exactly one cycle, in the
// cycle after busy; busy is low then, so a new request may be taken in that
// same cycle. Results cannot be held off and must be captured while out_valid
// is high. The byte stores have no reset: reading a cell never written since
// power-up returns an undefined byte. The stack pointer resets to FFFE.
module handheld_console_memory_bus_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_data,
  output      logic        out_valid,
  output      logic [15:0] out_read_data,
  output      logic [15:0] out_stack_value
);
  import hcmb_pkg::*;

  cmd_t cmd;

  hcmb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  hcmb_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_mode),
    .in_address      (in_address),
    .in_data         (in_data),
    .out_read_data   (out_read_data),
    .out_stack_value (out_stack_value)
  );

endmodule
`default_nettype wire

[rtl/core/hcmb_checker.sv]
`default_nettype none
module hcmb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  in_mode,
  input wire logic        out_valid,
  input wire logic [15:0] out_read_data
);
  import hcmb_pkg::*;

  logic accept;
  logic wr_mode;

  assign accept  = rst_n && start && !busy;
  assign wr_mode = (in_mode == MODE_WR_BYTE) || (in_mode == MODE_WR_WORD) ||
                   (in_mode == MODE_PUSH) || (in_mode == MODE_LOAD_SP);

  // A taken request occupies the bus for the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request taken but bus not busy next cycle");

  // The busy cycle is always followed by the result strobe
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("no result after busy cycle");

  // Every result traces back to a request taken before its busy cycle
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without a matching request");

  // Writes, pushes and stack loads return zero data
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && wr_mode) |-> ##2 (out_read_data == 16'h0000))
    else $error("write request returned nonzero data");

endmodule

bind handheld_console_memory_bus_unit hcmb_checker u_hcmb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_read_data (out_read_data)
);
`default_nettype wire
